[rtl/core/pmd_pkg.sv]
package pmd_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;
    localparam int COORD_W   = 32;
    localparam int SCALE_W   = 24;
    localparam int MASK_W    = 3;
    localparam int SUM_W     = COORD_W + 1;
    localparam int PROD_W    = SUM_W + SCALE_W + 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int RAD_W     = SQ_W + 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 1;

    localparam int S_TDATA_W = 2 * NUM_AXES * COORD_W;
    localparam int M_TDATA_W = ((ROOT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam int FRONT_LAT = 5;
    localparam int WRAP_LAT  = COORD_W + 2;
    localparam int SUM_LAT   = 1;
    localparam int ROOT_LAT  = ROOT_W;
    localparam int PIPE_LAT  = FRONT_LAT + WRAP_LAT + SUM_LAT + ROOT_LAT;
    localparam int SAT_DLY   = PIPE_LAT - FRONT_LAT;

    localparam logic [MASK_W-1:0]  AXIS_MASK_RST    = MASK_W'(7);
    localparam logic [SCALE_W-1:0] SCALE_FACTOR_RST = SCALE_W'(1) << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_MASK    = 8'd0,
        REG_SCALE_FACTOR = 8'd1,
        REG_OFFSET_X     = 8'd2,
        REG_OFFSET_Y     = 8'd3,
        REG_OFFSET_Z     = 8'd4,
        REG_PERIOD_X     = 8'd5,
        REG_PERIOD_Y     = 8'd6,
        REG_PERIOD_Z     = 8'd7
    } cfg_reg_t;

endpackage

[rtl/core/pmd_front.sv]
module pmd_front (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [pmd_pkg::COORD_W-1:0]   first,
    input  logic [pmd_pkg::COORD_W-1:0]   second,
    input  logic [pmd_pkg::COORD_W-1:0]   offset,
    input  logic [pmd_pkg::SCALE_W-1:0]   scale,
    input  logic                          mask_bit,
    output logic [pmd_pkg::COORD_W-1:0]   dist_abs,
    output logic                          sat
);
    import pmd_pkg::*;

    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  quot;
    logic signed [COORD_W-1:0] w_reg, w_next;
    logic signed [SUM_W-1:0]   d_reg, d_next;
    logic [COORD_W-1:0]        abs_reg, abs_next;
    logic [COORD_W-1:0]        v1_reg, v2_reg, v3_reg;
    logic                      sat3_reg, sat4_reg, sat5_reg, sat_next;
    logic                      in_range;

    assign sum_next  = $signed({second[COORD_W-1], second}) + $signed({offset[COORD_W-1], offset});
    assign prod_next = sum_reg * $signed({1'b0, scale});

    assign quot     = prod_reg >>> FRAC_BITS;
    assign in_range = (&quot[PROD_W-1:COORD_W-1]) || !(|quot[PROD_W-1:COORD_W-1]);
    assign sat_next = !in_range;

    always_comb begin
        if (in_range) begin
            w_next = quot[COORD_W-1:0];
        end else if (quot[PROD_W-1]) begin
            w_next = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            w_next = {1'b0, {(COORD_W-1){1'b1}}};
        end
    end

    assign d_next = mask_bit ? ($signed({v3_reg[COORD_W-1], v3_reg}) - $signed({w_reg[COORD_W-1], w_reg}))
                             : '0;
    assign abs_next = d_reg[SUM_W-1] ? COORD_W'(-d_reg) : d_reg[COORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg  <= sum_next;
            v1_reg   <= first;
            prod_reg <= prod_next;
            v2_reg   <= v1_reg;
            w_reg    <= w_next;
            sat3_reg <= sat_next;
            v3_reg   <= v2_reg;
            d_reg    <= d_next;
            sat4_reg <= sat3_reg;
            abs_reg  <= abs_next;
            sat5_reg <= sat4_reg;
        end
    end

    assign dist_abs = abs_reg;
    assign sat      = sat5_reg;

endmodule

[rtl/core/pmd_wrap.sv]
module pmd_wrap (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [pmd_pkg::COORD_W-1:0] dist_abs,
    input  logic [pmd_pkg::COORD_W-1:0] period,
    output logic [pmd_pkg::SQ_W-1:0]    dist_sq
);
    import pmd_pkg::*;

    logic [COORD_W-1:0] rem_reg  [COORD_W];
    logic [COORD_W-1:0] rem_next [COORD_W];
    logic [COORD_W-1:0] bits_reg  [COORD_W-1];
    logic [COORD_W-1:0] bits_next [COORD_W-1];
    logic [COORD_W-1:0] fold_reg, fold_next;
    logic [COORD_W-1:0] rem_last;
    logic [SQ_W-1:0]    sq_reg;

    for (genvar k = 0; k < COORD_W; k++) begin : g_stage
        logic [COORD_W-1:0] rem_prev;
        logic [COORD_W-1:0] bits_prev;
        logic [COORD_W:0]   trial;
        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign bits_prev = dist_abs;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign bits_prev = bits_reg[k-1];
        end
        assign trial = {rem_prev, bits_prev[COORD_W-1]};
        assign rem_next[k] = (trial >= {1'b0, period}) ? COORD_W'(trial - {1'b0, period})
                                                        : trial[COORD_W-1:0];
        if (k < COORD_W - 1) begin : g_shift
            assign bits_next[k] = {bits_prev[COORD_W-2:0], 1'b0};
        end
    end

    assign rem_last = rem_reg[COORD_W-1];

    always_comb begin
        if (period == '0) begin
            fold_next = rem_last;
        end else if ({rem_last, 1'b0} > {1'b0, period}) begin
            fold_next = period - rem_last;
        end else begin
            fold_next = rem_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < COORD_W; k++) begin
                rem_reg[k] <= rem_next[k];
            end
            for (int k = 0; k < COORD_W - 1; k++) begin
                bits_reg[k] <= bits_next[k];
            end
            fold_reg <= fold_next;
            sq_reg   <= SQ_W'(fold_reg) * SQ_W'(fold_reg);
        end
    end

    assign dist_sq = sq_reg;

endmodule

[rtl/core/pmd_isqrt.sv]
module pmd_isqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [pmd_pkg::RAD_W-1:0]   radicand,
    output logic [pmd_pkg::ROOT_W-1:0]  root
);
    import pmd_pkg::*;

    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_next [ROOT_W];
    logic [REM_W-1:0]  rem_reg   [ROOT_W-1];
    logic [REM_W-1:0]  rem_next  [ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg   [ROOT_W-1];
    logic [RAD_W-1:0]  rad_next  [ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [RAD_W-1:0]  rad_prev;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;
        if (k == 0) begin : g_first
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign rad_prev  = radicand;
        end else begin : g_rest
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign rad_prev  = rad_reg[k-1];
        end
        assign cur   = {rem_prev, rad_prev[RAD_W-1 -: 2]};
        assign trial = {1'b0, root_prev, 2'b01};
        assign ge    = (cur >= trial);
        assign root_next[k] = {root_prev[ROOT_W-2:0], ge};
        if (k < ROOT_W - 1) begin : g_carry
            assign rem_next[k] = ge ? REM_W'(cur - trial) : cur[REM_W-1:0];
            assign rad_next[k] = {rad_prev[RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_W; k++) begin
                root_reg[k] <= root_next[k];
            end
            for (int k = 0; k < ROOT_W - 1; k++) begin
                rem_reg[k] <= rem_next[k];
                rad_reg[k] <= rad_next[k];
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

[rtl/core/periodic_masked_distance.sv]
// Channel  | Direction | Payload, lowest bits first
// s_*      | in        | tdata: first_x, first_y, first_z, second_x, second_y, second_z
// m_*      | out       | tdata: dist_res (33 bits, zero padded to 40); tuser: saturated
// cfg_*    | in        | cfg_index: register number 0..7; cfg_data: register value
//
// One item per cycle while m_tready does not stall the pipeline. The
// remainder pipeline has 32 stages (one bit per stage) and the square root
// pipeline has 33 stages (one result bit per stage).
// aresetn clears the stage valid bits and loads the register defaults.
// A stall on m_tready freezes the whole pipeline; s_tready follows it.
module periodic_masked_distance (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z
    input  logic [pmd_pkg::S_TDATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // dist_res, then zero padding
    output logic [pmd_pkg::M_TDATA_W-1:0]       m_tdata,
    // saturated
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import pmd_pkg::*;

    logic [MASK_W-1:0]   axis_mask_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [COORD_W-1:0]  offset_reg [NUM_AXES];
    logic [COORD_W-1:0]  period_reg [NUM_AXES];

    logic                en;
    logic [PIPE_LAT-1:0] valid_reg;
    logic [SAT_DLY-1:0]  sat_reg;
    logic [COORD_W-1:0]  dist_abs [NUM_AXES];
    logic [NUM_AXES-1:0] axis_sat;
    logic [SQ_W-1:0]     dist_sq  [NUM_AXES];
    logic [RAD_W-1:0]    rad_reg, rad_next;
    logic [ROOT_W-1:0]   root;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_mask_reg <= AXIS_MASK_RST;
            scale_reg     <= SCALE_FACTOR_RST;
            for (int i = 0; i < NUM_AXES; i++) begin
                offset_reg[i] <= '0;
                period_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_AXIS_MASK:    axis_mask_reg <= cfg_data[MASK_W-1:0];
                REG_SCALE_FACTOR: scale_reg     <= cfg_data[SCALE_W-1:0];
                REG_OFFSET_X:     offset_reg[0] <= cfg_data[COORD_W-1:0];
                REG_OFFSET_Y:     offset_reg[1] <= cfg_data[COORD_W-1:0];
                REG_OFFSET_Z:     offset_reg[2] <= cfg_data[COORD_W-1:0];
                REG_PERIOD_X:     period_reg[0] <= cfg_data[COORD_W-1:0];
                REG_PERIOD_Y:     period_reg[1] <= cfg_data[COORD_W-1:0];
                REG_PERIOD_Z:     period_reg[2] <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // advance whenever the output stage is empty or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        pmd_front u_front (
            .aclk     (aclk),
            .en       (en),
            .first    (s_tdata[a*COORD_W +: COORD_W]),
            .second   (s_tdata[(NUM_AXES+a)*COORD_W +: COORD_W]),
            .offset   (offset_reg[a]),
            .scale    (scale_reg),
            .mask_bit (axis_mask_reg[a]),
            .dist_abs (dist_abs[a]),
            .sat      (axis_sat[a])
        );

        pmd_wrap u_wrap (
            .aclk     (aclk),
            .en       (en),
            .dist_abs (dist_abs[a]),
            .period   (period_reg[a]),
            .dist_sq  (dist_sq[a])
        );
    end

    assign rad_next = RAD_W'(dist_sq[0]) + RAD_W'(dist_sq[1]) + RAD_W'(dist_sq[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg <= rad_next;
            sat_reg <= {sat_reg[SAT_DLY-2:0], |axis_sat};
        end
    end

    pmd_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (rad_reg),
        .root     (root)
    );

    assign m_tdata = M_TDATA_W'(root);
    assign m_tuser = sat_reg[SAT_DLY-1];

endmodule

[sim/periodic_masked_distance_test.sv]
`timescale 1ns / 100ps

module periodic_masked_distance_test;

    import pmd_pkg::*;

    typedef struct packed {
        logic [NUM_AXES-1:0][COORD_W-1:0] second;
        logic [NUM_AXES-1:0][COORD_W-1:0] first;
    } point_pair_t;

    typedef struct packed {
        logic [ROOT_W-1:0] dist_res;
        logic              sat;
    } distance_t;

    typedef struct packed {
        logic [MASK_W-1:0]                mask;
        logic [SCALE_W-1:0]               scale;
        logic [NUM_AXES-1:0][COORD_W-1:0] offset;
        logic [NUM_AXES-1:0][COORD_W-1:0] period;
    } settings_t;

    typedef struct {
        int          setting;
        point_pair_t pair;
        bit          typed;
        distance_t   want;
    } directed_row_t;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd8;
    localparam longint COORD_MAX   = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN   = -(longint'(1) << (COORD_W - 1));
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     ITEMS_PER_SETTING = 200;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    distance_t     pending_distances[$];
    directed_row_t directed_rows[$];
    settings_t     directed_cfg[5];
    settings_t     live_regs;
    distance_t     oldest;
    int            failures = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            hold_request = 0;
    int            hold_left = 0;

    periodic_masked_distance u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns aclk = ~aclk;

    function automatic distance_t predict_distance(point_pair_t pr, settings_t c);
        int           i;
        int           b;
        longint       shifted;
        longint       scaled;
        longint       diff;
        logic [63:0]  mag;
        logic [63:0]  other;
        logic [65:0]  sum_sq;
        logic [ROOT_W-1:0] root;
        logic [ROOT_W-1:0] trial;
        logic [65:0]  trial_sq;
        distance_t    r;
        r.sat  = 1'b0;
        sum_sq = '0;
        for (i = 0; i < NUM_AXES; i++) begin
            shifted = longint'($signed(pr.second[i])) + longint'($signed(c.offset[i]));
            scaled  = (shifted * longint'(c.scale)) >>> FRAC_BITS;
            if (scaled > COORD_MAX) begin
                scaled = COORD_MAX;
                r.sat  = 1'b1;
            end else if (scaled < COORD_MIN) begin
                scaled = COORD_MIN;
                r.sat  = 1'b1;
            end
            diff = c.mask[i] ? longint'($signed(pr.first[i])) - scaled : 0;
            mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
            if (c.period[i] != '0) begin
                mag   = mag % {32'b0, c.period[i]};
                other = {32'b0, c.period[i]} - mag;
                if (other < mag) begin
                    mag = other;
                end
            end
            sum_sq = sum_sq + mag * mag;
        end
        root = '0;
        for (b = ROOT_W - 1; b >= 0; b--) begin
            trial    = root | (ROOT_W'(1) << b);
            trial_sq = trial * trial;
            if (trial_sq <= sum_sq) begin
                root = trial;
            end
        end
        r.dist_res = root;
        return r;
    endfunction

    function automatic logic [COORD_W-1:0] random_coord();
        case ($urandom_range(4))
            0: return COORD_W'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
            1: return COORD_W'($urandom_range(0, 32'h0FFF_FFFF)) - 32'h0800_0000;
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    default: return '0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic point_pair_t random_pair();
        int          i;
        point_pair_t pr;
        for (i = 0; i < NUM_AXES; i++) begin
            pr.first[i] = random_coord();
            if ($urandom_range(2) == 0) begin
                pr.second[i] = pr.first[i] + COORD_W'($urandom_range(0, 32'h0008_0000))
                    - 32'h0004_0000;
            end else begin
                pr.second[i] = random_coord();
            end
        end
        return pr;
    endfunction

    function automatic settings_t random_settings();
        int        i;
        settings_t c;
        c.mask = MASK_W'($urandom_range(7));
        case ($urandom_range(4)) inside
            0, 1: c.scale = SCALE_FACTOR_RST;
            2: c.scale = '1;
            3: c.scale = SCALE_W'($urandom_range(0, 32'h0002_0000));
            default: c.scale = SCALE_W'($urandom);
        endcase
        for (i = 0; i < NUM_AXES; i++) begin
            case ($urandom_range(3))
                0: c.offset[i] = '0;
                1: c.offset[i] = COORD_W'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
                2: c.offset[i] = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                default: c.offset[i] = $urandom;
            endcase
            case ($urandom_range(4)) inside
                0: c.period[i] = '0;
                1: c.period[i] = '1;
                2, 3: c.period[i] = COORD_W'($urandom_range(1, 32'h0040_0000));
                default: c.period[i] = $urandom;
            endcase
        end
        return c;
    endfunction

    task automatic add_row(input int setting, input logic [COORD_W-1:0] fx, fy, fz,
                           input logic [COORD_W-1:0] sx, sy, sz,
                           input bit typed, input logic [ROOT_W-1:0] want_dist,
                           input logic sat);
        directed_row_t row;
        row.setting       = setting;
        row.pair.first    = {fz, fy, fx};
        row.pair.second   = {sz, sy, sx};
        row.typed         = typed;
        row.want.dist_res = want_dist;
        row.want.sat      = sat;
        directed_rows.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx) inside
            REG_AXIS_MASK:    live_regs.mask = value[MASK_W-1:0];
            REG_SCALE_FACTOR: live_regs.scale = value[SCALE_W-1:0];
            REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z: live_regs.offset[idx - REG_OFFSET_X] = value;
            REG_PERIOD_X, REG_PERIOD_Y, REG_PERIOD_Z: live_regs.period[idx - REG_PERIOD_X] = value;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic load_settings(input settings_t c);
        int i;
        write_reg(REG_AXIS_MASK, ($urandom & ~32'h7) | CFG_DATA_W'(c.mask));
        write_reg(REG_SCALE_FACTOR, ($urandom & 32'hFF00_0000) | CFG_DATA_W'(c.scale));
        for (i = 0; i < NUM_AXES; i++) begin
            write_reg(CFG_IDX_W'(REG_OFFSET_X + i), c.offset[i]);
            write_reg(CFG_IDX_W'(REG_PERIOD_X + i), c.period[i]);
        end
        write_reg(REG_SPARE | CFG_IDX_W'($urandom), $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_distances.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic idle_sender();
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_pair(input point_pair_t pr, input distance_t want);
        s_tvalid <= 1'b1;
        s_tdata  <= pr;
        do @(posedge aclk); while (!s_tready);
        pending_distances.push_back(want);
        @(negedge aclk);
    endtask

    // receiver side: random stalls, plus long holds on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_distances.size() == 0) begin
                $error("result item with nothing expected: dist_res %0h saturated %0b",
                       m_tdata[ROOT_W-1:0], m_tuser);
                failures++;
            end else begin
                oldest = pending_distances.pop_front();
                if (m_tdata[ROOT_W-1:0] !== oldest.dist_res) begin
                    $error("dist_res mismatch: expected %0h, actual %0h",
                           oldest.dist_res, m_tdata[ROOT_W-1:0]);
                    failures++;
                end
                if (m_tuser !== oldest.sat) begin
                    $error("saturated mismatch: expected %0b, actual %0b", oldest.sat, m_tuser);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("periodic_masked_distance_test failed");
            $finish;
        end
    end

    initial begin
        int            k;
        int            mode;
        int            phase;
        int            n;
        int            current;
        directed_row_t row;
        point_pair_t   pr;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        live_regs.mask   = AXIS_MASK_RST;
        live_regs.scale  = SCALE_FACTOR_RST;
        live_regs.offset = '0;
        live_regs.period = '0;

        directed_cfg[0] = live_regs;
        directed_cfg[1] = live_regs;
        directed_cfg[1].scale = '1;
        directed_cfg[2] = directed_cfg[1];
        directed_cfg[2].mask  = 3'b000;
        directed_cfg[3] = live_regs;
        directed_cfg[3].mask  = 3'b101;
        directed_cfg[3].offset = {32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        directed_cfg[4] = live_regs;
        directed_cfg[4].period = {32'h0000_0001, 32'hFFFF_FFFF, 32'h000A_0000};

        // reset values
        add_row(0, 0, 0, 0, 0, 0, 0, 1, 33'h0, 0);
        add_row(0, 32'h0001_0000, 0, 0, 0, 0, 0, 1, 33'h1_0000, 0);
        add_row(0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 1, 33'h5_0000, 0);
        add_row(0, 32'hFFFD_0000, 32'hFFFC_0000, 0, 0, 0, 0, 1, 33'h5_0000, 0);
        add_row(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1, 33'hFFFF_FFFF, 0);
        add_row(0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, 33'hFFFF_FFFF, 0);
        add_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        add_row(0, 0, 0, 32'h0001_0000, 0, 0, 32'h0002_0000, 1, 33'h1_0000, 0);
        // largest scale factor: clipping both ways, rounding toward minus infinity
        add_row(1, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 1, 33'h7FFF_FFFF, 1);
        add_row(1, 0, 0, 0, 32'h8000_0000, 0, 0, 1, 33'h8000_0000, 1);
        add_row(1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 32'h0000_0001, 0, 0, 0, 0, 0);
        add_row(1, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 0, 0, 0);
        // every axis masked off, clipping still flagged
        add_row(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                32'h7FFF_FFFF, 0, 0, 1, 33'h0, 1);
        add_row(2, 0, 0, 0, 0, 0, 0, 1, 33'h0, 0);
        // extreme offsets with y masked
        add_row(3, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0);
        add_row(3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
        // wraparound: beyond the period, over half, exactly half, exactly one period
        add_row(4, 32'h000C_0000, 0, 0, 0, 0, 0, 1, 33'h2_0000, 0);
        add_row(4, 32'h0007_0000, 0, 0, 0, 0, 0, 1, 33'h3_0000, 0);
        add_row(4, 32'h0005_0000, 0, 0, 0, 0, 0, 1, 33'h5_0000, 0);
        add_row(4, 32'h000A_0000, 0, 0, 0, 0, 0, 1, 33'h0, 0);
        add_row(4, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_2345,
                32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0);
        add_row(4, 32'hFFF6_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                32'h0013_0000, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 20;
        recv_idle_pct = 50;
        current = 0;
        for (k = 0; k < directed_rows.size(); k++) begin
            row = directed_rows[k];
            if (row.setting != current) begin
                s_tvalid <= 1'b0;
                drain_results();
                load_settings(directed_cfg[row.setting]);
                current = row.setting;
            end
            idle_sender();
            send_pair(row.pair, row.typed ? row.want : predict_distance(row.pair, live_regs));
        end

        for (mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 88 : 0;
            recv_idle_pct = (mode == 0) ? 88 : (mode == 1) ? 20 : 0;
            for (phase = 0; phase < 2; phase++) begin
                s_tvalid <= 1'b0;
                drain_results();
                load_settings(random_settings());
                for (n = 0; n < ITEMS_PER_SETTING; n++) begin
                    if (mode == 2 && phase == 0 && n == 40) begin
                        hold_request = 400;
                    end
                    if (mode == 2 && phase == 0 && n == 150) begin
                        s_tvalid <= 1'b0;
                        while (pending_distances.size() != 0) @(negedge aclk);
                        @(negedge aclk);
                    end
                    idle_sender();
                    pr = random_pair();
                    send_pair(pr, predict_distance(pr, live_regs));
                end
            end
        end

        s_tvalid <= 1'b0;
        while (pending_distances.size() != 0) @(negedge aclk);
        repeat (PIPE_LAT + 8) @(negedge aclk);
        if (failures == 0) begin
            $display("periodic_masked_distance_test passed");
        end else begin
            $display("periodic_masked_distance_test failed");
        end
        $finish;
    end

endmodule
